// ===== rtl/rpsm_pkg.sv =====
// -----------------------------------------------------------------------------
// rpsm_pkg
// shared codes and field widths of the rule precedence / strong marker block
// -----------------------------------------------------------------------------
package rpsm_pkg;

   localparam int IDX_BITS     = 10;   // rule index field
   localparam int REC_BITS     = 16;   // record number field
   localparam int OUT_CNT_BITS = 16;   // cover count field of a read beat

   typedef enum logic [1:0] {
      KIND_CORRECT = 2'd0,
      KIND_WRONG   = 2'd1,
      KIND_EOR     = 2'd2,
      KIND_READ    = 2'd3
   } kind_type;

   typedef enum logic {
      RES_MISCLASS = 1'b0,
      RES_READ     = 1'b1
   } result_kind_type;

endpackage

// ===== rtl/rpsm_if.sv =====
// -----------------------------------------------------------------------------
// rpsm channel interfaces
// valid/ready channels for match items in and result beats out
// -----------------------------------------------------------------------------
interface rpsm_req_if import rpsm_pkg::*; ();
   logic                valid;
   logic                ready;
   kind_type            kind;
   logic [IDX_BITS-1:0] rule_index;

   modport source (output valid, kind, rule_index, input ready);
   modport sink   (input valid, kind, rule_index, output ready);
endinterface

interface rpsm_rsp_if import rpsm_pkg::*; ();
   logic                    valid;
   logic                    ready;
   result_kind_type         result_kind;
   logic [REC_BITS-1:0]     record_number;
   logic [IDX_BITS-1:0]     correct_rule;
   logic                    correct_valid;
   logic [IDX_BITS-1:0]     wrong_rule;
   logic [OUT_CNT_BITS-1:0] cover_count;
   logic                    strong_flag;

   modport source (output valid, result_kind, record_number, correct_rule, correct_valid,
                   wrong_rule, cover_count, strong_flag, input ready);
   modport sink   (input valid, result_kind, record_number, correct_rule, correct_valid,
                   wrong_rule, cover_count, strong_flag, output ready);
endinterface

// ===== rtl/rpsm_store.sv =====
// -----------------------------------------------------------------------------
// rpsm_store
// per-rule state memory: counter and strong bit, clear sweep, write bypass
// -----------------------------------------------------------------------------
module rpsm_store #(
   parameter int DEPTH  = 1024,
   parameter int ADDR_W = 10,
   parameter int DATA_W = 17
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [DATA_W-1:0] rd_data,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [DATA_W-1:0] wr_data,
   output logic              busy
);

   logic [DATA_W-1:0] mem [DEPTH];
   logic [DATA_W-1:0] q_ff;
   logic              fwd_ff;
   logic [DATA_W-1:0] fwd_data_ff;
   logic              clr_ff;
   logic              clr_in;
   logic [ADDR_W-1:0] clr_addr_ff;
   logic [ADDR_W-1:0] clr_addr_in;
   logic              mem_we;
   logic [ADDR_W-1:0] mem_waddr;
   logic [DATA_W-1:0] mem_wdata;

   // sweep zeros through every entry after reset
   always_comb begin
      clr_in      = clr_ff;
      clr_addr_in = clr_addr_ff;
      if (clr_ff) begin
         clr_addr_in = clr_addr_ff + 1'b1;
         if (clr_addr_ff == ADDR_W'(DEPTH - 1)) begin
            clr_in = 1'b0;
         end
      end
   end

   assign mem_we    = clr_ff | wr_en;
   assign mem_waddr = clr_ff ? clr_addr_ff : wr_addr;
   assign mem_wdata = clr_ff ? '0 : wr_data;

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff      <= 1'b1;
         clr_addr_ff <= '0;
      end else begin
         clr_ff      <= clr_in;
         clr_addr_ff <= clr_addr_in;
      end
   end

   // read-first port, a write landing on the address being read is bypassed
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      if (rd_en) begin
         q_ff        <= mem[rd_addr];
         fwd_ff      <= wr_en && (wr_addr == rd_addr);
         fwd_data_ff <= wr_data;
      end
   end

   assign rd_data = fwd_ff ? fwd_data_ff : q_ff;
   assign busy    = clr_ff;

endmodule

// ===== rtl/rule_precedence_strong_marker.sv =====
// -----------------------------------------------------------------------------
// rule_precedence_strong_marker
// first-match tracking per record, cover counting and strong marking per rule
// -----------------------------------------------------------------------------
//
//  channel   dir  beat contents
//  --------  ---  ---------------------------------------------------------
//  req_chan  in   kind, rule_index (match element, end of record, rule read)
//  rsp_chan  out  result_kind, record_number, correct_rule, correct_valid,
//                 wrong_rule, cover_count, strong_flag
//
//  one beat per cycle is taken while req_chan.ready is high; an end-of-record
//  or read beat reads the rule memory into the memory stage at its accepting
//  edge, and its result is loaded into the output register once that is free
//  after reset a clear pass zeroes all MAX_RULES entries of the rule memory
//  and req_chan.ready stays low until the pass ends
//  a stalled rsp_chan holds one result while one more end-of-record or read
//  beat waits in the memory stage; req_chan.ready then stays low for every
//  kind of beat, match elements included, until the output register frees
//
module rule_precedence_strong_marker
   import rpsm_pkg::*;
#(
   parameter int MAX_RULES  = 1024,
   parameter int COUNT_BITS = 16
) (
   input  logic          clock,
   input  logic          reset,
   rpsm_req_if.sink      req_chan,
   rpsm_rsp_if.source    rsp_chan
);

   localparam int ADDR_W = (MAX_RULES > 2) ? $clog2(MAX_RULES) : 1;
   localparam int DATA_W = COUNT_BITS + 1;

   // ---------------------------------------------------------------- intake
   logic                req_fire;
   logic                store_busy;
   logic                out_free;
   logic                s1_fire;
   logic [31:0]         idx_wide;
   logic                idx_in_range;
   logic [ADDR_W-1:0]   idx_addr;
   logic [31:0]         fc_wide;

   // per-record first matches
   logic [IDX_BITS-1:0] fc_ff, fc_in;
   logic                hc_ff, hc_in;
   logic [IDX_BITS-1:0] fw_ff, fw_in;
   logic                hw_ff, hw_in;
   logic [REC_BITS-1:0] rec_ff, rec_in;

   // memory stage: end-of-record or read waiting on the rule memory
   logic                s1_valid_ff, s1_valid_in;
   kind_type            s1_kind_ff, s1_kind_in;
   logic                s1_ok_ff, s1_ok_in;      // read index in range
   logic [ADDR_W-1:0]   s1_addr_ff, s1_addr_in;
   logic [IDX_BITS-1:0] s1_fc_ff, s1_fc_in;
   logic                s1_hc_ff, s1_hc_in;
   logic [IDX_BITS-1:0] s1_fw_ff, s1_fw_in;
   logic                s1_hw_ff, s1_hw_in;
   logic [REC_BITS-1:0] s1_rec_ff, s1_rec_in;

   logic                rd_en;
   logic [ADDR_W-1:0]   rd_addr;
   logic [DATA_W-1:0]   rd_data;
   logic                wr_en;
   logic [DATA_W-1:0]   wr_data;

   logic [COUNT_BITS-1:0] cur_cnt;
   logic [COUNT_BITS-1:0] new_cnt;
   logic                  cur_strong;
   logic                  new_strong;
   logic                  s1_emit;
   logic [47:0]           cnt_wide;

   // output register
   logic                    rsp_valid_ff, rsp_valid_in;
   result_kind_type         rsp_kind_ff, rsp_kind_in;
   logic [REC_BITS-1:0]     rsp_rec_ff, rsp_rec_in;
   logic [IDX_BITS-1:0]     rsp_cr_ff, rsp_cr_in;
   logic                    rsp_cv_ff, rsp_cv_in;
   logic [IDX_BITS-1:0]     rsp_wr_ff, rsp_wr_in;
   logic [OUT_CNT_BITS-1:0] rsp_cnt_ff, rsp_cnt_in;
   logic                    rsp_st_ff, rsp_st_in;

   assign out_free = !rsp_valid_ff || rsp_chan.ready;
   assign s1_fire  = s1_valid_ff && out_free;
   assign req_chan.ready = !store_busy && (!s1_valid_ff || out_free);
   assign req_fire = req_chan.valid && req_chan.ready;

   assign idx_wide     = 32'(req_chan.rule_index);
   assign idx_in_range = idx_wide < 32'(MAX_RULES);
   assign idx_addr     = idx_wide[ADDR_W-1:0];
   assign fc_wide      = 32'(fc_ff);

   // first-match capture, cleared by end of record
   always_comb begin
      fc_in  = fc_ff;
      hc_in  = hc_ff;
      fw_in  = fw_ff;
      hw_in  = hw_ff;
      rec_in = rec_ff;
      if (req_fire) begin
         case (req_chan.kind)
            KIND_CORRECT: begin
               if (idx_in_range && !hc_ff) begin
                  fc_in = req_chan.rule_index;
                  hc_in = 1'b1;
               end
            end
            KIND_WRONG: begin
               if (idx_in_range && !hw_ff) begin
                  fw_in = req_chan.rule_index;
                  hw_in = 1'b1;
               end
            end
            KIND_EOR: begin
               fc_in  = '0;
               hc_in  = 1'b0;
               fw_in  = '0;
               hw_in  = 1'b0;
               rec_in = rec_ff + 1'b1;
            end
            default: begin
            end
         endcase
      end
   end

   // memory read issue for end of record (first correct rule) or a rule read
   assign rd_en   = req_fire && (req_chan.kind == KIND_EOR || req_chan.kind == KIND_READ);
   assign rd_addr = (req_chan.kind == KIND_EOR) ? fc_wide[ADDR_W-1:0] :
                    (idx_in_range ? idx_addr : '0);

   always_comb begin
      s1_valid_in = s1_valid_ff;
      s1_kind_in  = s1_kind_ff;
      s1_ok_in    = s1_ok_ff;
      s1_addr_in  = s1_addr_ff;
      s1_fc_in    = s1_fc_ff;
      s1_hc_in    = s1_hc_ff;
      s1_fw_in    = s1_fw_ff;
      s1_hw_in    = s1_hw_ff;
      s1_rec_in   = s1_rec_ff;
      if (rd_en) begin
         s1_valid_in = 1'b1;
         s1_kind_in  = req_chan.kind;
         s1_ok_in    = idx_in_range;
         s1_addr_in  = rd_addr;
         s1_fc_in    = fc_ff;
         s1_hc_in    = hc_ff;
         s1_fw_in    = fw_ff;
         s1_hw_in    = hw_ff;
         s1_rec_in   = rec_ff;
      end else if (s1_fire) begin
         s1_valid_in = 1'b0;
      end
   end

   // ---------------------------------------------------------------- rule memory
   rpsm_store #(
      .DEPTH  (MAX_RULES),
      .ADDR_W (ADDR_W),
      .DATA_W (DATA_W)
   ) u_store (
      .clock   (clock),
      .reset   (reset),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data),
      .wr_en   (wr_en),
      .wr_addr (s1_addr_ff),
      .wr_data (wr_data),
      .busy    (store_busy)
   );

   // ---------------------------------------------------------------- update
   assign cur_cnt    = rd_data[COUNT_BITS-1:0];
   assign cur_strong = rd_data[COUNT_BITS];
   // saturating increment
   assign new_cnt    = (&cur_cnt) ? cur_cnt : cur_cnt + 1'b1;
   // already strong, correct rule ahead of the wrong one, or no wrong rule at all
   assign new_strong = cur_strong | !s1_hw_ff | (s1_fc_ff < s1_fw_ff);
   assign wr_data    = {new_strong, new_cnt};
   assign wr_en      = s1_fire && (s1_kind_ff == KIND_EOR) && s1_hc_ff;
   // a rule read, or wrong rule first, or only a wrong rule
   assign s1_emit    = (s1_kind_ff == KIND_READ) ||
                       (s1_hc_ff ? (s1_hw_ff && (s1_fw_ff < s1_fc_ff)) : s1_hw_ff);
   assign cnt_wide   = 48'(cur_cnt);

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_kind_in  = rsp_kind_ff;
      rsp_rec_in   = rsp_rec_ff;
      rsp_cr_in    = rsp_cr_ff;
      rsp_cv_in    = rsp_cv_ff;
      rsp_wr_in    = rsp_wr_ff;
      rsp_cnt_in   = rsp_cnt_ff;
      rsp_st_in    = rsp_st_ff;
      if (s1_fire && s1_emit) begin
         rsp_valid_in = 1'b1;
         if (s1_kind_ff == KIND_READ) begin
            rsp_kind_in = RES_READ;
            rsp_rec_in  = '0;
            rsp_cr_in   = '0;
            rsp_cv_in   = 1'b0;
            rsp_wr_in   = '0;
            rsp_cnt_in  = s1_ok_ff ? cnt_wide[OUT_CNT_BITS-1:0] : '0;
            rsp_st_in   = s1_ok_ff && cur_strong;
         end else begin
            rsp_kind_in = RES_MISCLASS;
            rsp_rec_in  = s1_rec_ff;
            rsp_cr_in   = s1_hc_ff ? s1_fc_ff : '0;
            rsp_cv_in   = s1_hc_ff;
            rsp_wr_in   = s1_fw_ff;
            rsp_cnt_in  = '0;
            rsp_st_in   = 1'b0;
         end
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // ---------------------------------------------------------------- registers
   always_ff @(posedge clock) begin
      if (reset) begin
         fc_ff        <= '0;
         hc_ff        <= 1'b0;
         fw_ff        <= '0;
         hw_ff        <= 1'b0;
         rec_ff       <= '0;
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         fc_ff        <= fc_in;
         hc_ff        <= hc_in;
         fw_ff        <= fw_in;
         hw_ff        <= hw_in;
         rec_ff       <= rec_in;
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_kind_ff  <= s1_kind_in;
      s1_ok_ff    <= s1_ok_in;
      s1_addr_ff  <= s1_addr_in;
      s1_fc_ff    <= s1_fc_in;
      s1_hc_ff    <= s1_hc_in;
      s1_fw_ff    <= s1_fw_in;
      s1_hw_ff    <= s1_hw_in;
      s1_rec_ff   <= s1_rec_in;
      rsp_kind_ff <= rsp_kind_in;
      rsp_rec_ff  <= rsp_rec_in;
      rsp_cr_ff   <= rsp_cr_in;
      rsp_cv_ff   <= rsp_cv_in;
      rsp_wr_ff   <= rsp_wr_in;
      rsp_cnt_ff  <= rsp_cnt_in;
      rsp_st_ff   <= rsp_st_in;
   end

   assign rsp_chan.valid         = rsp_valid_ff;
   assign rsp_chan.result_kind   = rsp_kind_ff;
   assign rsp_chan.record_number = rsp_rec_ff;
   assign rsp_chan.correct_rule  = rsp_cr_ff;
   assign rsp_chan.correct_valid = rsp_cv_ff;
   assign rsp_chan.wrong_rule    = rsp_wr_ff;
   assign rsp_chan.cover_count   = rsp_cnt_ff;
   assign rsp_chan.strong_flag   = rsp_st_ff;

`ifndef SYNTH
   // no beat taken while the clear pass runs
   a_no_intake_while_clearing: assert property (@(posedge clock) disable iff (reset)
      store_busy |-> !req_chan.ready)
      else $error("beat accepted during clear pass");

   // memory writes only come from an end of record with a correct rule
   a_write_source: assert property (@(posedge clock) disable iff (reset)
      wr_en |-> (s1_valid_ff && s1_kind_ff == KIND_EOR && s1_hc_ff && out_free))
      else $error("unexpected rule memory write");

   // a new result only appears after the memory stage retired
   a_result_origin: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(s1_fire))
      else $error("result without a retired memory stage");

   // record number advances once per end of record
   a_record_step: assert property (@(posedge clock) disable iff (reset)
      (req_fire && req_chan.kind == KIND_EOR) |=> (rec_ff == REC_BITS'($past(rec_ff) + 1'b1)))
      else $error("record counter did not advance");
`endif

endmodule
